// ===== hdl/wk3_pkg.sv =====
package wk3_pkg;

  // controller states
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_QDIV,
    ST_QFIN,
    ST_RCMUL,
    ST_RCFIN,
    ST_USMUL,
    ST_TLOAD,
    ST_TDIV,
    ST_TFIN,
    ST_T1MUL,
    ST_T1FIN,
    ST_T2MUL,
    ST_T2FIN,
    ST_T3AMUL,
    ST_T3AFIN,
    ST_T3BMUL,
    ST_T3FIN,
    ST_PLOAD,
    ST_PDIV,
    ST_FIN
  } state_e;

  // datapath commands
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_ACCEPT,
    CMD_DIV_STEP,
    CMD_MUL_STEP,
    CMD_Q_DONE,
    CMD_RC_DONE,
    CMD_TAU_LOAD,
    CMD_TAU_DONE,
    CMD_T1_DONE,
    CMD_T2_DONE,
    CMD_T3A_DONE,
    CMD_T3_DONE,
    CMD_P_LOAD,
    CMD_FINISH
  } cmd_e;

  typedef struct packed {
    cmd_e op;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
  } stat_t;

  // configuration register indexes
  localparam logic [2:0] REG_RESISTANCE = 3'd0;
  localparam logic [2:0] REG_COMPLIANCE = 3'd1;
  localparam logic [2:0] REG_IMPEDANCE  = 3'd2;
  localparam logic [2:0] REG_STEP_US    = 3'd3;
  localparam logic [2:0] REG_SECOND     = 3'd4;
  localparam logic [2:0] REG_DENSITY    = 3'd5;
  localparam logic [2:0] REG_VENOUS     = 3'd6;

  // reset values of the registers
  localparam logic [31:0] RST_RESISTANCE = 32'd292736;
  localparam logic [31:0] RST_COMPLIANCE = 32'd100072738;
  localparam logic [31:0] RST_IMPEDANCE  = 32'd21838;
  localparam logic [19:0] RST_STEP_US    = 20'd1000;
  localparam logic        RST_SECOND     = 1'b1;
  localparam logic [11:0] RST_DENSITY    = 12'd1060;
  localparam logic [31:0] RST_VENOUS     = 32'd0;

  localparam logic [19:0] US_PER_S = 20'd1000000;

  // last count value of each serial phase (steps minus one)
  localparam logic [6:0] QDIV_LAST  = 7'd39;
  localparam logic [6:0] RCMUL_LAST = 7'd31;
  localparam logic [6:0] USMUL_LAST = 7'd19;
  localparam logic [6:0] TDIV_LAST  = 7'd84;
  localparam logic [6:0] T1MUL_LAST = 7'd32;
  localparam logic [6:0] T2MUL_LAST = 7'd52;
  localparam logic [6:0] T3A_LAST   = 7'd31;
  localparam logic [6:0] T3B_LAST   = 7'd52;
  localparam logic [6:0] PDIV_LAST  = 7'd127;

endpackage

// ===== hdl/wk3_ctrl.sv =====
module wk3_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  wk3_pkg::stat_t stat_i,
  output wk3_pkg::cmd_t  cmd_o
);

  wk3_pkg::state_e state_q, state_d;
  logic [6:0]      cnt_q, cnt_d;
  logic            last;

  assign last = (cnt_q == 7'd0);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      wk3_pkg::ST_IDLE:   if (in_valid_i) state_d = wk3_pkg::ST_QDIV;
      wk3_pkg::ST_QDIV:   if (last) state_d = wk3_pkg::ST_QFIN;
      wk3_pkg::ST_QFIN:   state_d = wk3_pkg::ST_RCMUL;
      wk3_pkg::ST_RCMUL:  if (last) state_d = wk3_pkg::ST_RCFIN;
      wk3_pkg::ST_RCFIN:  state_d = wk3_pkg::ST_USMUL;
      wk3_pkg::ST_USMUL:  if (last) state_d = wk3_pkg::ST_TLOAD;
      wk3_pkg::ST_TLOAD:  state_d = wk3_pkg::ST_TDIV;
      wk3_pkg::ST_TDIV:   if (last) state_d = wk3_pkg::ST_TFIN;
      wk3_pkg::ST_TFIN:   state_d = wk3_pkg::ST_T1MUL;
      wk3_pkg::ST_T1MUL:  if (last) state_d = wk3_pkg::ST_T1FIN;
      wk3_pkg::ST_T1FIN:  state_d = wk3_pkg::ST_T2MUL;
      wk3_pkg::ST_T2MUL:  if (last) state_d = wk3_pkg::ST_T2FIN;
      wk3_pkg::ST_T2FIN:  state_d = wk3_pkg::ST_T3AMUL;
      wk3_pkg::ST_T3AMUL: if (last) state_d = wk3_pkg::ST_T3AFIN;
      wk3_pkg::ST_T3AFIN: state_d = wk3_pkg::ST_T3BMUL;
      wk3_pkg::ST_T3BMUL: if (last) state_d = wk3_pkg::ST_T3FIN;
      wk3_pkg::ST_T3FIN:  state_d = wk3_pkg::ST_PLOAD;
      wk3_pkg::ST_PLOAD:  state_d = wk3_pkg::ST_PDIV;
      wk3_pkg::ST_PDIV:   if (last) state_d = wk3_pkg::ST_FIN;
      wk3_pkg::ST_FIN:    if (!stat_i.out_busy) state_d = wk3_pkg::ST_IDLE;
      default:            state_d = wk3_pkg::ST_IDLE;
    endcase
  end

  // step counter, loaded on entry to a serial phase
  always_comb begin
    cnt_d = cnt_q - 7'd1;
    if (state_d != state_q) begin
      case (state_d)
        wk3_pkg::ST_QDIV:   cnt_d = wk3_pkg::QDIV_LAST;
        wk3_pkg::ST_RCMUL:  cnt_d = wk3_pkg::RCMUL_LAST;
        wk3_pkg::ST_USMUL:  cnt_d = wk3_pkg::USMUL_LAST;
        wk3_pkg::ST_TDIV:   cnt_d = wk3_pkg::TDIV_LAST;
        wk3_pkg::ST_T1MUL:  cnt_d = wk3_pkg::T1MUL_LAST;
        wk3_pkg::ST_T2MUL:  cnt_d = wk3_pkg::T2MUL_LAST;
        wk3_pkg::ST_T3AMUL: cnt_d = wk3_pkg::T3A_LAST;
        wk3_pkg::ST_T3BMUL: cnt_d = wk3_pkg::T3B_LAST;
        wk3_pkg::ST_PDIV:   cnt_d = wk3_pkg::PDIV_LAST;
        default:            cnt_d = 7'd0;
      endcase
    end
  end

  // command outputs
  always_comb begin
    in_ready_o = 1'b0;
    cmd_o.op   = wk3_pkg::CMD_NONE;
    case (state_q)
      wk3_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) cmd_o.op = wk3_pkg::CMD_ACCEPT;
      end
      wk3_pkg::ST_QDIV,
      wk3_pkg::ST_TDIV,
      wk3_pkg::ST_PDIV:   cmd_o.op = wk3_pkg::CMD_DIV_STEP;
      wk3_pkg::ST_RCMUL,
      wk3_pkg::ST_USMUL,
      wk3_pkg::ST_T1MUL,
      wk3_pkg::ST_T2MUL,
      wk3_pkg::ST_T3AMUL,
      wk3_pkg::ST_T3BMUL: cmd_o.op = wk3_pkg::CMD_MUL_STEP;
      wk3_pkg::ST_QFIN:   cmd_o.op = wk3_pkg::CMD_Q_DONE;
      wk3_pkg::ST_RCFIN:  cmd_o.op = wk3_pkg::CMD_RC_DONE;
      wk3_pkg::ST_TLOAD:  cmd_o.op = wk3_pkg::CMD_TAU_LOAD;
      wk3_pkg::ST_TFIN:   cmd_o.op = wk3_pkg::CMD_TAU_DONE;
      wk3_pkg::ST_T1FIN:  cmd_o.op = wk3_pkg::CMD_T1_DONE;
      wk3_pkg::ST_T2FIN:  cmd_o.op = wk3_pkg::CMD_T2_DONE;
      wk3_pkg::ST_T3AFIN: cmd_o.op = wk3_pkg::CMD_T3A_DONE;
      wk3_pkg::ST_T3FIN:  cmd_o.op = wk3_pkg::CMD_T3_DONE;
      wk3_pkg::ST_PLOAD:  cmd_o.op = wk3_pkg::CMD_P_LOAD;
      wk3_pkg::ST_FIN:    if (!stat_i.out_busy) cmd_o.op = wk3_pkg::CMD_FINISH;
      default:            cmd_o.op = wk3_pkg::CMD_NONE;
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wk3_pkg::ST_IDLE;
      cnt_q   <= 7'd0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// ===== hdl/wk3_datapath.sv =====
module wk3_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  wk3_pkg::cmd_t      cmd_i,
  output wk3_pkg::stat_t     stat_o,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic signed [31:0] mass_flow_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] proximal_pressure_o,
  output logic signed [31:0] volume_flow_o,
  output logic               saturated_o
);

  // configuration
  logic [31:0] res_q, cmp_q, imp_q, pout_q;
  logic [19:0] dt_q;
  logic        so_q;
  logic [11:0] dens_q;

  // history: p1/q1 last, p2/q2 the one before
  logic [31:0] p1_q, p2_q, q1_q, q2_q;

  // item working registers
  logic         fneg_q, qsat_q, tneg_q, pneg_q;
  logic [31:0]  q_q;
  logic [52:0]  tau_q;
  logic [127:0] dvd_q, quo_q, mcand_q, prod_q, acc_q;
  logic [63:0]  rem_q, dsr_q, mplier_q;

  // output register
  logic        ov_q, osat_q;
  logic [31:0] opres_q, oflow_q;

  // effective density and step
  logic [11:0] dens_eff;
  logic [19:0] dt_eff;
  assign dens_eff = (dens_q == 12'd0) ? 12'd1 : dens_q;
  assign dt_eff   = (dt_q == 20'd0) ? 20'd1 : dt_q;

  // flow magnitude and rounded dividend for the density divide
  logic [31:0] mmag;
  logic [39:0] qdvd;
  assign mmag = mass_flow_i[31] ? (~mass_flow_i + 32'd1) : mass_flow_i;
  assign qdvd = {mmag, 8'h00} + {29'd0, dens_eff[11:1]};

  // restoring divider step
  logic [64:0] rem_sh, rem_sub;
  logic        ge;
  assign rem_sh  = {rem_q, dvd_q[127]};
  assign rem_sub = rem_sh - {1'b0, dsr_q};
  assign ge      = (rem_sh >= {1'b0, dsr_q});

  // volume flow clamp
  logic [39:0] qmag;
  logic [31:0] qm32, qval;
  logic        qover;
  always_comb begin
    qmag  = quo_q[39:0];
    qover = fneg_q ? (qmag > 40'h0080000000) : (qmag > 40'h007FFFFFFF);
    if (qover) qm32 = fneg_q ? 32'h80000000 : 32'h7FFFFFFF;
    else       qm32 = qmag[31:0];
    qval = fneg_q ? (~qm32 + 32'd1) : qm32;
  end

  // term operands
  logic [33:0] mq, mqmag;
  logic [34:0] p1x, p2x, bp, bpmag;
  logic [35:0] qx, q1x, q2x, bq, bqmag;
  logic [32:0] rz;
  always_comb begin
    mq    = so_q ? {q_q[31], q_q, 1'b0} : {{2{q_q[31]}}, q_q};
    mqmag = mq[33] ? (~mq + 34'd1) : mq;
    p1x   = {{3{p1_q[31]}}, p1_q};
    p2x   = {{3{p2_q[31]}}, p2_q};
    bp    = so_q ? ((p1x << 2) - p2x) : p1x;
    bpmag = bp[34] ? (~bp + 35'd1) : bp;
    qx    = {{4{q_q[31]}}, q_q};
    q1x   = {{4{q1_q[31]}}, q1_q};
    q2x   = {{4{q2_q[31]}}, q2_q};
    bq    = so_q ? ((qx << 1) + qx - (q1x << 2) + q2x) : (qx - q1x);
    bqmag = bq[35] ? (~bq + 36'd1) : bq;
    rz    = {1'b0, res_q} + {1'b0, imp_q};
  end

  // denominator, back pressure term and signed term addends
  logic [63:0]  tau64, den16;
  logic [127:0] pinit, t16, t0, acc_t16, acc_t0, accmag;
  always_comb begin
    tau64   = {11'd0, tau_q};
    den16   = so_q ? (64'h20000 + (tau64 << 1) + tau64) : (64'h10000 + tau64);
    pinit   = {{96{pout_q[31]}}, pout_q} << (so_q ? 33 : 32);
    t16     = prod_q << 16;
    t0      = prod_q;
    acc_t16 = acc_q + (tneg_q ? (~t16 + 128'd1) : t16);
    acc_t0  = acc_q + (tneg_q ? (~t0 + 128'd1) : t0);
    accmag  = acc_q[127] ? (~acc_q + 128'd1) : acc_q;
  end

  // pressure rounding and clamp
  logic [127:0] rnd;
  logic [111:0] shq, plim;
  logic         pover;
  logic [31:0]  pm32, pval;
  always_comb begin
    rnd   = quo_q + 128'd32768;
    shq   = rnd[127:16];
    plim  = pneg_q ? 112'h80000000 : 112'h7FFFFFFF;
    pover = (shq > plim);
    pm32  = pover ? plim[31:0] : shq[31:0];
    pval  = pneg_q ? (~pm32 + 32'd1) : pm32;
  end

  // configuration writes and history
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q  <= wk3_pkg::RST_RESISTANCE;
      cmp_q  <= wk3_pkg::RST_COMPLIANCE;
      imp_q  <= wk3_pkg::RST_IMPEDANCE;
      dt_q   <= wk3_pkg::RST_STEP_US;
      so_q   <= wk3_pkg::RST_SECOND;
      dens_q <= wk3_pkg::RST_DENSITY;
      pout_q <= wk3_pkg::RST_VENOUS;
      p1_q   <= 32'd0;
      p2_q   <= 32'd0;
      q1_q   <= 32'd0;
      q2_q   <= 32'd0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          wk3_pkg::REG_RESISTANCE: res_q  <= cfg_data_i;
          wk3_pkg::REG_COMPLIANCE: cmp_q  <= cfg_data_i;
          wk3_pkg::REG_IMPEDANCE:  imp_q  <= cfg_data_i;
          wk3_pkg::REG_STEP_US:    dt_q   <= cfg_data_i[19:0];
          wk3_pkg::REG_SECOND:     so_q   <= cfg_data_i[0];
          wk3_pkg::REG_DENSITY:    dens_q <= cfg_data_i[11:0];
          wk3_pkg::REG_VENOUS:     pout_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.op == wk3_pkg::CMD_FINISH) begin
        p2_q <= p1_q;
        p1_q <= pval;
        q2_q <= q1_q;
        q1_q <= q_q;
      end
    end
  end

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (cmd_i.op == wk3_pkg::CMD_FINISH) begin
      ov_q <= 1'b1;
    end else if (out_ready_i) begin
      ov_q <= 1'b0;
    end
  end

  // serial multiplier, divider and term accumulation
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      wk3_pkg::CMD_ACCEPT: begin
        fneg_q <= mass_flow_i[31];
        dvd_q  <= {qdvd, 88'd0};
        dsr_q  <= {52'd0, dens_eff};
        rem_q  <= 64'd0;
        quo_q  <= 128'd0;
      end
      wk3_pkg::CMD_DIV_STEP: begin
        dvd_q <= dvd_q << 1;
        rem_q <= ge ? rem_sub[63:0] : rem_sh[63:0];
        quo_q <= {quo_q[126:0], ge};
      end
      wk3_pkg::CMD_MUL_STEP: begin
        if (mplier_q[0]) prod_q <= prod_q + mcand_q;
        mcand_q  <= mcand_q << 1;
        mplier_q <= mplier_q >> 1;
      end
      wk3_pkg::CMD_Q_DONE: begin
        q_q      <= qval;
        qsat_q   <= qover;
        mcand_q  <= {96'd0, res_q};
        mplier_q <= {32'd0, cmp_q};
        prod_q   <= 128'd0;
      end
      wk3_pkg::CMD_RC_DONE: begin
        mcand_q  <= prod_q;
        mplier_q <= {44'd0, wk3_pkg::US_PER_S};
        prod_q   <= 128'd0;
      end
      wk3_pkg::CMD_TAU_LOAD: begin
        dvd_q <= (prod_q + ({108'd0, dt_eff} << 31)) << 43;
        dsr_q <= {12'd0, dt_eff, 32'd0};
        rem_q <= 64'd0;
        quo_q <= 128'd0;
      end
      wk3_pkg::CMD_TAU_DONE: begin
        tau_q    <= quo_q[52:0];
        acc_q    <= pinit;
        tneg_q   <= mq[33];
        mcand_q  <= {94'd0, mqmag};
        mplier_q <= {31'd0, rz};
        prod_q   <= 128'd0;
      end
      wk3_pkg::CMD_T1_DONE: begin
        acc_q    <= acc_t16;
        tneg_q   <= bp[34];
        mcand_q  <= {93'd0, bpmag};
        mplier_q <= tau64;
        prod_q   <= 128'd0;
      end
      wk3_pkg::CMD_T2_DONE: begin
        acc_q    <= acc_t16;
        tneg_q   <= bq[35];
        mcand_q  <= {92'd0, bqmag};
        mplier_q <= {32'd0, imp_q};
        prod_q   <= 128'd0;
      end
      wk3_pkg::CMD_T3A_DONE: begin
        mcand_q  <= prod_q;
        mplier_q <= tau64;
        prod_q   <= 128'd0;
      end
      wk3_pkg::CMD_T3_DONE: begin
        acc_q <= acc_t0;
      end
      wk3_pkg::CMD_P_LOAD: begin
        pneg_q <= acc_q[127];
        dvd_q  <= accmag;
        dsr_q  <= den16;
        rem_q  <= 64'd0;
        quo_q  <= 128'd0;
      end
      wk3_pkg::CMD_FINISH: begin
        opres_q <= pval;
        oflow_q <= q_q;
        osat_q  <= qsat_q | pover;
      end
      default: ;
    endcase
  end

  assign stat_o.out_busy    = ov_q & ~out_ready_i;
  assign out_valid_o         = ov_q;
  assign proximal_pressure_o = opres_q;
  assign volume_flow_o       = oflow_q;
  assign saturated_o         = osat_q;

endmodule

// ===== hdl/three_element_windkessel_step.sv =====
// Three-element windkessel outlet step: each accepted item (outlet mass flow)
// yields one result with the new proximal pressure, the volume flow used and
// a saturation flag. Between acceptance and the result being registered at the
// output, an item runs through the bit-serial shift-add multiplier and the
// restoring divider (one bit per cycle each): the density divide, the R*C
// product and its scaling by 10^6, the tau divide, the numerator terms and the
// final pressure divide. The next item is accepted in the cycle after a result
// is registered, while that result may still wait to be taken.
// Configuration writes take effect at once and belong only to idle periods.
module three_element_windkessel_step (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] mass_flow_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] proximal_pressure_o,
  output logic signed [31:0] volume_flow_o,
  output logic               saturated_o
);

  wk3_pkg::cmd_t  cmd;
  wk3_pkg::stat_t stat;

  // sequencer
  wk3_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // arithmetic and state
  wk3_datapath u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .stat_o              (stat),
    .cfg_we_i            (cfg_we_i),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .mass_flow_i         (mass_flow_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .proximal_pressure_o (proximal_pressure_o),
    .volume_flow_o       (volume_flow_o),
    .saturated_o         (saturated_o)
  );

  // an accepted item keeps the block busy in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input taken twice in a row");

  // a result is never written over one that is still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.op == wk3_pkg::CMD_FINISH) |-> !(out_valid_o && !out_ready_i))
    else $error("pending result overwritten");

  // a fresh result returns the sequencer to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> in_ready_o)
    else $error("not idle after result");

endmodule

// ===== sim/three_element_windkessel_step_tb.sv =====
module three_element_windkessel_step_tb;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int LONG_HOLD = 3000;
  localparam int N_RANDOM = 900;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [2:0]         cfg_index_i;
  logic [31:0]        cfg_data_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic signed [31:0] mass_flow_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic signed [31:0] proximal_pressure_o;
  logic signed [31:0] volume_flow_o;
  logic               saturated_o;

  typedef struct packed {
    logic signed [31:0] pres;
    logic signed [31:0] flow;
    logic               sat;
  } outlet_t;

  // one row of the directed table: a register write or an item
  typedef struct {
    bit                 is_cfg;
    logic [2:0]         idx;
    logic [31:0]        val;
    logic signed [31:0] mass;
    bit                 typed;
    outlet_t            res;
  } row_t;

  // mirrored registers and history
  logic [31:0] m_res, m_comp, m_imp, m_ven;
  logic [19:0] m_dt;
  logic        m_second;
  logic [11:0] m_dens;
  longint      p_hist [2];
  longint      q_hist [2];

  outlet_t outlet_q [$];
  int      errors;
  int      idle_cycles;
  bit      stim_done;
  int      results_seen;

  three_element_windkessel_step i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .mass_flow_i,
    .out_valid_o, .out_ready_i, .proximal_pressure_o, .volume_flow_o, .saturated_o
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic signed [191:0] wide(longint v);
    logic signed [191:0] r;
    r = v;
    return r;
  endfunction

  // solves one windkessel step and advances the mirrored history
  function automatic outlet_t windkessel_solve(logic signed [31:0] mf);
    outlet_t r;
    longint mflow, dens, dt, q, m, fden, bp, bq, tau, den, lim;
    logic [63:0] mmag, qmag;
    logic [191:0] t, dtw;
    logic signed [191:0] num, mag, quo;
    bit neg;
    mflow = mf;
    dens = (m_dens == 0) ? 1 : m_dens;
    dt = (m_dt == 0) ? 1 : m_dt;
    r.sat = 1'b0;
    mmag = (mflow < 0) ? -mflow : mflow;
    qmag = (mmag * 256 + dens / 2) / dens;
    if (mflow < 0) begin
      if (qmag > 64'd2147483648) begin
        qmag = 64'd2147483648;
        r.sat = 1'b1;
      end
      q = -longint'(qmag);
    end else begin
      if (qmag > 64'd2147483647) begin
        qmag = 64'd2147483647;
        r.sat = 1'b1;
      end
      q = qmag;
    end
    // tau with 16 fraction bits, round half up
    t = m_res;
    t = t * m_comp;
    t = t * 1000000;
    dtw = dt;
    t = t + (dtw << 31);
    t = t / (dtw << 32);
    tau = t[63:0];
    if (m_second) begin
      m = 2; fden = 3;
      bp = 4 * p_hist[0] - p_hist[1];
      bq = 3 * q - 4 * q_hist[0] + q_hist[1];
    end else begin
      m = 1; fden = 1;
      bp = p_hist[0];
      bq = q - q_hist[0];
    end
    num = ((wide(m * q) * wide(longint'(m_res) + longint'(m_imp))) <<< 16)
        + ((wide(bp) * wide(tau)) <<< 16)
        + (wide(bq) * wide(longint'(m_imp)) * wide(tau))
        + (wide(m * longint'($signed(m_ven))) <<< 32);
    den = m * 65536 + fden * tau;
    neg = num < 0;
    mag = neg ? -num : num;
    quo = mag / wide(den);
    quo = (quo + 32768) >>> 16;
    lim = neg ? 64'sd2147483648 : 64'sd2147483647;
    if (quo > wide(lim)) begin
      quo = wide(lim);
      r.sat = 1'b1;
    end
    r.pres = neg ? -quo[31:0] : quo[31:0];
    r.flow = q[31:0];
    p_hist[1] = p_hist[0];
    p_hist[0] = r.pres;
    q_hist[1] = q_hist[0];
    q_hist[0] = r.flow;
    return r;
  endfunction

  task automatic wait_drained();
    wait (outlet_q.size() == 0);
    repeat (4) @(posedge clk_i);
  endtask

  // register write, mirrored with the register widths
  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    case (idx)
      wk3_pkg::REG_RESISTANCE: m_res = val;
      wk3_pkg::REG_COMPLIANCE: m_comp = val;
      wk3_pkg::REG_IMPEDANCE:  m_imp = val;
      wk3_pkg::REG_STEP_US:    m_dt = val[19:0];
      wk3_pkg::REG_SECOND:     m_second = val[0];
      wk3_pkg::REG_DENSITY:    m_dens = val[11:0];
      wk3_pkg::REG_VENOUS:     m_ven = val;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic int gap_len();
    int k;
    k = $urandom_range(0, 99);
    if (k < 45) return 0;
    if (k < 90) return $urandom_range(1, 4);
    if (k < 98) return $urandom_range(5, 40);
    return $urandom_range(100, 600);
  endfunction

  // offers one item and waits for its acceptance
  task automatic send_item(logic signed [31:0] mf, bit typed, outlet_t typed_res);
    outlet_t r;
    int g;
    in_valid_i <= 1'b1;
    mass_flow_i <= mf;
    do @(negedge clk_i); while (!in_ready_o);
    r = windkessel_solve(mf);
    outlet_q.push_back(typed ? typed_res : r);
    @(posedge clk_i);
    g = gap_len();
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g - 1) @(posedge clk_i);
      @(posedge clk_i);
    end
  endtask

  function automatic logic signed [31:0] rand_mass();
    int k;
    k = $urandom_range(0, 9);
    case (k)
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2, 3: return $signed($urandom_range(0, 4000)) - 2000;
      4, 5, 6: return $signed($urandom_range(0, 2000000)) - 1000000;
      default: return $urandom;
    endcase
  endfunction

  // random register set, sometimes near the reset values
  task automatic random_settings();
    if ($urandom_range(0, 1)) begin
      reg_write(wk3_pkg::REG_RESISTANCE, $urandom_range(1, 2000000));
      reg_write(wk3_pkg::REG_COMPLIANCE, $urandom_range(0, 400000000));
      reg_write(wk3_pkg::REG_IMPEDANCE, $urandom_range(0, 200000));
    end else begin
      reg_write(wk3_pkg::REG_RESISTANCE, $urandom);
      reg_write(wk3_pkg::REG_COMPLIANCE, $urandom);
      reg_write(wk3_pkg::REG_IMPEDANCE, $urandom);
    end
    reg_write(wk3_pkg::REG_STEP_US,
              $urandom_range(0, 1) ? $urandom_range(1, 1000000) : $urandom);
    reg_write(wk3_pkg::REG_SECOND, $urandom);
    reg_write(wk3_pkg::REG_DENSITY,
              $urandom_range(0, 3) ? $urandom_range(1, 4095) : $urandom);
    reg_write(wk3_pkg::REG_VENOUS,
              $urandom_range(0, 1) ? $signed($urandom_range(0, 8000000)) - 4000000
                                   : $urandom);
  endtask

  // stimulus
  initial begin
    row_t rows [$];
    row_t rw;
    outlet_t zero_res;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = wk3_pkg::REG_RESISTANCE;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    mass_flow_i = '0;
    stim_done = 1'b0;
    errors = 0;
    m_res = wk3_pkg::RST_RESISTANCE; m_comp = wk3_pkg::RST_COMPLIANCE;
    m_imp = wk3_pkg::RST_IMPEDANCE; m_dt = wk3_pkg::RST_STEP_US;
    m_second = wk3_pkg::RST_SECOND; m_dens = wk3_pkg::RST_DENSITY;
    m_ven = wk3_pkg::RST_VENOUS;
    p_hist = '{0, 0}; q_hist = '{0, 0};
    zero_res = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    rw = '{0, wk3_pkg::REG_RESISTANCE, 0, 0, 1, zero_res}; rows.push_back(rw);
    rw = '{0, wk3_pkg::REG_RESISTANCE, 0, 530, 0, zero_res}; rows.push_back(rw);
    rw = '{0, wk3_pkg::REG_RESISTANCE, 0, 32'sh7fffffff, 0, zero_res}; rows.push_back(rw);
    rw = '{0, wk3_pkg::REG_RESISTANCE, 0, 32'sh80000000, 0, zero_res}; rows.push_back(rw);
    rw = '{0, wk3_pkg::REG_RESISTANCE, 0, -1, 0, zero_res}; rows.push_back(rw);
    rw = '{0, wk3_pkg::REG_RESISTANCE, 0, 2, 0, zero_res}; rows.push_back(rw);
    rw = '{1, wk3_pkg::REG_SECOND, 0, 0, 0, zero_res}; rows.push_back(rw);
    rw = '{0, wk3_pkg::REG_RESISTANCE, 0, 1000000, 0, zero_res}; rows.push_back(rw);
    rw = '{0, wk3_pkg::REG_RESISTANCE, 0, -1000000, 0, zero_res}; rows.push_back(rw);
    // density zero taken as one, flow saturates
    rw = '{1, wk3_pkg::REG_DENSITY, 0, 0, 0, zero_res}; rows.push_back(rw);
    rw = '{0, wk3_pkg::REG_RESISTANCE, 0, 32'sh7fffffff, 0, zero_res}; rows.push_back(rw);
    rw = '{0, wk3_pkg::REG_RESISTANCE, 0, 32'sh80000000, 0, zero_res}; rows.push_back(rw);
    // resistance zero with step zero and top venous pressure
    rw = '{1, wk3_pkg::REG_RESISTANCE, 0, 0, 0, zero_res}; rows.push_back(rw);
    rw = '{1, wk3_pkg::REG_STEP_US, 0, 0, 0, zero_res}; rows.push_back(rw);
    rw = '{1, wk3_pkg::REG_VENOUS, 32'h7fffffff, 0, 0, zero_res}; rows.push_back(rw);
    rw = '{0, wk3_pkg::REG_RESISTANCE, 0, 12345, 0, zero_res}; rows.push_back(rw);
    rw = '{0, wk3_pkg::REG_RESISTANCE, 0, -777, 0, zero_res}; rows.push_back(rw);
    // all extremes, second order, step above range, bad index ignored
    rw = '{1, wk3_pkg::REG_RESISTANCE, 32'hffffffff, 0, 0, zero_res}; rows.push_back(rw);
    rw = '{1, wk3_pkg::REG_COMPLIANCE, 32'hffffffff, 0, 0, zero_res}; rows.push_back(rw);
    rw = '{1, wk3_pkg::REG_IMPEDANCE, 32'hffffffff, 0, 0, zero_res}; rows.push_back(rw);
    rw = '{1, wk3_pkg::REG_STEP_US, 32'hfffff, 0, 0, zero_res}; rows.push_back(rw);
    rw = '{1, wk3_pkg::REG_SECOND, 1, 0, 0, zero_res}; rows.push_back(rw);
    rw = '{1, wk3_pkg::REG_DENSITY, 4095, 0, 0, zero_res}; rows.push_back(rw);
    rw = '{1, wk3_pkg::REG_VENOUS, 32'h80000000, 0, 0, zero_res}; rows.push_back(rw);
    rw = '{1, 3'd7, 32'h12345678, 0, 0, zero_res}; rows.push_back(rw);
    rw = '{0, wk3_pkg::REG_RESISTANCE, 0, 32'sh7fffffff, 0, zero_res}; rows.push_back(rw);
    rw = '{0, wk3_pkg::REG_RESISTANCE, 0, 32'sh80000000, 0, zero_res}; rows.push_back(rw);
    rw = '{0, wk3_pkg::REG_RESISTANCE, 0, 5, 0, zero_res}; rows.push_back(rw);
    rw = '{1, wk3_pkg::REG_STEP_US, 1, 0, 0, zero_res}; rows.push_back(rw);
    rw = '{1, wk3_pkg::REG_COMPLIANCE, 0, 0, 0, zero_res}; rows.push_back(rw);
    rw = '{1, wk3_pkg::REG_IMPEDANCE, 0, 0, 0, zero_res}; rows.push_back(rw);
    rw = '{0, wk3_pkg::REG_RESISTANCE, 0, -100000, 0, zero_res}; rows.push_back(rw);
    rw = '{0, wk3_pkg::REG_RESISTANCE, 0, 100000, 0, zero_res}; rows.push_back(rw);

    foreach (rows[i]) begin
      if (rows[i].is_cfg) begin
        // drop valid at the edge that took the last item
        in_valid_i <= 1'b0;
        wait_drained();
        reg_write(rows[i].idx, rows[i].val);
      end else begin
        send_item(rows[i].mass, rows[i].typed, rows[i].res);
      end
    end

    // random phases
    for (int ph = 0; ph < 12; ph++) begin
      in_valid_i <= 1'b0;
      wait_drained();
      random_settings();
      for (int n = 0; n < N_RANDOM / 12; n++) send_item(rand_mass(), 0, zero_res);
    end
    in_valid_i <= 1'b0;
    stim_done = 1'b1;
  end

  // receiver with random stalls and one long hold
  initial begin
    int hold;
    bit held;
    outlet_t e, a;
    out_ready_i = 1'b0;
    hold = 0;
    held = 0;
    results_seen = 0;
    forever begin
      @(posedge clk_i);
      if (!held && results_seen == 40) begin
        held = 1;
        hold = LONG_HOLD;
      end
      if (hold > 0) begin
        hold--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) < 70);
        if ($urandom_range(0, 199) == 0) hold = $urandom_range(50, 600);
      end
      @(negedge clk_i);
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        a = '{proximal_pressure_o, volume_flow_o, saturated_o};
        if (outlet_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result: %0d %0d %0d", a.pres, a.flow, a.sat);
        end else begin
          e = outlet_q.pop_front();
          if (a !== e) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: pressure %0d/%0d flow %0d/%0d sat %0d/%0d (exp/act)",
                       e.pres, a.pres, e.flow, a.flow, e.sat, a.sat);
          end
        end
      end
    end
  end

  // watchdog on handshake activity
  initial begin
    idle_cycles = 0;
    forever begin
      @(negedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // end of run
  initial begin
    wait (stim_done);
    wait (outlet_q.size() == 0);
    repeat (600) @(posedge clk_i);
    if (errors == 0 && outlet_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
